### src/shp_pkg.sv
// Package: shared types and constants for the SipHash-2-4-128 fixed-length core.
package shp_pkg;

    // Round counts (defaults for the top-level parameters)
    localparam int COMPRESS_ROUNDS_DEF = 2;
    localparam int FINAL_ROUNDS_DEF    = 4;

    // Field widths
    localparam int WORD_W      = 64;
    localparam int CFG_INDEX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH = 1'b1;

    // Initialization constants and tweaks
    localparam logic [WORD_W-1:0] SEED0       = 64'h736f6d6570736575;
    localparam logic [WORD_W-1:0] SEED1       = 64'h646f72616e646f6d;
    localparam logic [WORD_W-1:0] SEED2       = 64'h6c7967656e657261;
    localparam logic [WORD_W-1:0] SEED3       = 64'h7465646279746573;
    localparam logic [WORD_W-1:0] WIDE_TWEAK  = 64'h00000000000000ee;
    localparam logic [WORD_W-1:0] HIGH_TWEAK  = 64'h00000000000000dd;
    localparam logic [WORD_W-1:0] LENGTH_WORD = 64'h1000000000000000;

    // The four state words
    typedef struct packed {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] d;
    } t_lanes;

    // Everything that travels down the pipeline with one message
    typedef struct packed {
        t_lanes            lanes;
        logic [WORD_W-1:0] msg_low;
        logic [WORD_W-1:0] msg_high;
        logic [WORD_W-1:0] hash_low;
    } t_item;

endpackage

### src/shp_in_if.sv
// Interface: message channel (valid/ready plus two message words).
interface shp_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] message_low;
    logic [63:0] message_high;

    modport source (output valid, output message_low, output message_high, input ready);
    modport sink   (input valid, input message_low, input message_high, output ready);
endinterface

### src/shp_out_if.sv
// Interface: hash channel (valid/ready plus two hash words).
interface shp_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_low;
    logic [63:0] hash_high;

    modport source (output valid, output hash_low, output hash_high, input ready);
    modport sink   (input valid, input hash_low, input hash_high, output ready);
endinterface

### src/shp_stage.sv
// Module: one pipeline stage, i.e. the word injections for its slot and one SipRound.
module shp_stage #(
    parameter int STAGE_IDX       = 0,
    parameter int COMPRESS_ROUNDS = shp_pkg::COMPRESS_ROUNDS_DEF,
    parameter int FINAL_ROUNDS    = shp_pkg::FINAL_ROUNDS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  shp_pkg::t_item i_item,
    output logic          o_valid,
    output shp_pkg::t_item o_item
);
    import shp_pkg::*;

    // Stage slots where words enter or leave the state
    localparam int ABS1_IDX = COMPRESS_ROUNDS;
    localparam int ABS2_IDX = 2 * COMPRESS_ROUNDS;
    localparam int FIN1_IDX = 3 * COMPRESS_ROUNDS;
    localparam int FIN2_IDX = 3 * COMPRESS_ROUNDS + FINAL_ROUNDS;

    logic   r_valid;
    t_item  r_item;
    t_item  n_item;
    t_lanes w_pre;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                               input int unsigned n);
        rotl = (x << n) | (x >> (WORD_W - n));
    endfunction

    function automatic t_lanes sip_round(input t_lanes s);
        t_lanes r;
        r = s;
        r.a = r.a + r.b;
        r.b = rotl(r.b, 13) ^ r.a;
        r.a = rotl(r.a, 32);
        r.c = r.c + r.d;
        r.d = rotl(r.d, 16) ^ r.c;
        r.a = r.a + r.d;
        r.d = rotl(r.d, 21) ^ r.a;
        r.c = r.c + r.b;
        r.b = rotl(r.b, 17) ^ r.c;
        r.c = rotl(r.c, 32);
        sip_round = r;
    endfunction

    // Injections ahead of the round, fixed by this stage's slot
    always_comb begin
        n_item = i_item;
        w_pre  = i_item.lanes;
        if (STAGE_IDX == 0) begin
            w_pre.d = w_pre.d ^ i_item.msg_low;
        end
        if (STAGE_IDX == ABS1_IDX) begin
            w_pre.a = w_pre.a ^ i_item.msg_low;
            w_pre.d = w_pre.d ^ i_item.msg_high;
        end
        if (STAGE_IDX == ABS2_IDX) begin
            w_pre.a = w_pre.a ^ i_item.msg_high;
            w_pre.d = w_pre.d ^ LENGTH_WORD;
        end
        if (STAGE_IDX == FIN1_IDX) begin
            w_pre.a = w_pre.a ^ LENGTH_WORD;
            w_pre.c = w_pre.c ^ WIDE_TWEAK;
        end
        if (STAGE_IDX == FIN2_IDX) begin
            // low hash word is the XOR of the state words after the first finalization
            n_item.hash_low = i_item.lanes.a ^ i_item.lanes.b ^ i_item.lanes.c
                            ^ i_item.lanes.d;
            w_pre.b = w_pre.b ^ HIGH_TWEAK;
        end
        n_item.lanes = sip_round(w_pre);
    end

    // Valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### src/siphash_2_4_128_fixed16_core.sv
// Top level: SipHash-2-4-128 over a 16-byte message, one SipRound per pipeline stage.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+------------------------------
//   i_in     | in  | valid / ready      | message_low, message_high
//   o_out    | out | valid / ready      | hash_low, hash_high
//   i_cfg_*  | in  | write enable only  | index (0 key_low, 1 key_high), data
//
// One message per cycle is taken while the pipeline is not held, and each
// message passes through every stage, one SipRound per stage.
// Synchronous active-low reset clears the stage valid bits and both key words.
// When the last stage holds a hash that is not taken, the whole pipeline holds
// and i_in.ready drops; nothing is lost or repeated.
module siphash_2_4_128_fixed16_core #(
    parameter int COMPRESS_ROUNDS = shp_pkg::COMPRESS_ROUNDS_DEF,
    parameter int FINAL_ROUNDS    = shp_pkg::FINAL_ROUNDS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    shp_in_if.sink                          i_in,
    shp_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [shp_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [shp_pkg::WORD_W-1:0]      i_cfg_data
);
    import shp_pkg::*;

    localparam int NUM_STAGES = 3 * COMPRESS_ROUNDS + 2 * FINAL_ROUNDS;

    logic [WORD_W-1:0] r_key_low;
    logic [WORD_W-1:0] r_key_high;
    logic              w_adv;
    logic [NUM_STAGES:0] w_valid;
    t_item             w_item [NUM_STAGES+1];

    // Key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_KEY_LOW:  r_key_low  <= i_cfg_data;
                REG_KEY_HIGH: r_key_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline moves unless the output stage holds an untaken transfer
    assign w_adv      = !w_valid[NUM_STAGES] || o_out.ready;
    assign i_in.ready = w_adv;

    // Seed state from key and constants
    always_comb begin
        w_item[0].lanes.a  = SEED0 ^ r_key_low;
        w_item[0].lanes.b  = SEED1 ^ r_key_high ^ WIDE_TWEAK;
        w_item[0].lanes.c  = SEED2 ^ r_key_low;
        w_item[0].lanes.d  = SEED3 ^ r_key_high;
        w_item[0].msg_low  = i_in.message_low;
        w_item[0].msg_high = i_in.message_high;
        w_item[0].hash_low = '0;
    end
    assign w_valid[0] = i_in.valid;

    // Round stages
    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
        shp_stage #(
            .STAGE_IDX       (g),
            .COMPRESS_ROUNDS (COMPRESS_ROUNDS),
            .FINAL_ROUNDS    (FINAL_ROUNDS)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (w_valid[g]),
            .i_item  (w_item[g]),
            .o_valid (w_valid[g+1]),
            .o_item  (w_item[g+1])
        );
    end

    // Output transfer
    assign o_out.valid     = w_valid[NUM_STAGES];
    assign o_out.hash_low  = w_item[NUM_STAGES].hash_low;
    assign o_out.hash_high = w_item[NUM_STAGES].lanes.a ^ w_item[NUM_STAGES].lanes.b
                           ^ w_item[NUM_STAGES].lanes.c ^ w_item[NUM_STAGES].lanes.d;

    // A blocked output stalls the input side
    a_stall_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !i_in.ready)
        else $error("input accepted while output stalled");

    // Stage occupancy freezes during a stall
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_adv && $past(i_rst_n)) |=> $stable(w_valid[NUM_STAGES:1]))
        else $error("pipeline moved during stall");

    // Reset empties the output stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid right after reset");

endmodule
